// File: hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Types and codes shared by the sparse matrix-vector block.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int IDX_W      = 10;
	localparam int VAL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] FUNC_VEC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_NONZERO   = 2'd1;
	localparam logic [1:0] FUNC_ROW_END   = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic                    row_last;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row_number;
		logic signed [VAL_W-1:0] row_sum;
		logic                    saturated;
	} out_t;

endpackage

// File: hw/rtl/csm_ram.sv
// ----------------------------------------------------------------------------
// csm_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/csr_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// Sparse matrix times dense vector, matrix streamed in CSR row order.
// ----------------------------------------------------------------------------
// Usage: the input channel carries vector writes (func 0), matrix nonzeros
// (func 1, column index and Q16.16 value) and row ends (func 2). Load the
// vector first, then stream nonzeros row by row; a nonzero with row_last or
// a row-end transfer closes the row and yields one output transfer with the
// row number, the Q16.16 row sum and a saturation flag.
// Throughput: one input transfer per cycle while in_ready is high. The vector
// store is a RAM read at acceptance; the multiply and the accumulate each take
// one stage and the narrowing feeds the output FIFO, so a row result is offered
// on the output once the closing transfer has passed these stages and been queued.
// Stall: results queue in an 8-entry output FIFO. in_ready drops only when
// queued plus in-flight results would fill it, so the core never stalls.
// Reset: accumulator, saturation flag, row counter and FIFO clear. Vector
// contents are undefined until written; no clearing pass is made.
// ----------------------------------------------------------------------------
module csr_sparse_matvec #(
	parameter int VEC_DEPTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  csm_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output csm_pkg::out_t  out_data
);

	import csm_pkg::*;

	localparam int ADDR_W = $clog2(VEC_DEPTH);

	logic                    in_fire;
	logic                    out_fire;
	logic                    in_range;
	logic [ADDR_W-1:0]       addr;
	logic [VAL_W-1:0]        rd_data;

	logic                    v_s1, close_s1, mac_s1, inr_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic                    v_s2, close_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic                    v_s3, sat_s3;
	logic signed [ACC_W-1:0] fin_s3;
	logic [IDX_W-1:0]        row_s3;

	logic signed [ACC_W-1:0] acc_q;
	logic                    sat_q;
	logic [IDX_W-1:0]        row_q;

	logic signed [ACC_W-1:0] sum;
	logic                    ovf;
	logic signed [ACC_W-1:0] acc_next;
	logic                    sat_next;
	logic signed [ACC_W-1:0] shifted;
	logic                    fits;
	out_t                    res;

	out_t                    fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]      wptr_q, rptr_q;
	logic [FIFO_AW:0]        cnt_q;
	logic [FIFO_AW:0]        pending;

	assign in_range = 32'(in_data.index) < VEC_DEPTH;
	assign addr     = ADDR_W'(in_data.index);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	csm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(VEC_DEPTH)
	) u_vec (
		.clk  (clk),
		.we   (in_fire && in_data.func == FUNC_VEC_WRITE && in_range),
		.waddr(addr),
		.wdata(in_data.value),
		.raddr(addr),
		.rdata(rd_data)
	);

	assign pending = (FIFO_AW+1)'(v_s1 && close_s1) + (FIFO_AW+1)'(v_s2 && close_s2)
		+ (FIFO_AW+1)'(v_s3);
	assign in_ready = (cnt_q + pending) < (FIFO_AW+1)'(FIFO_DEPTH);

	// stage 1: vector entry arrives from RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire && (in_data.func == FUNC_NONZERO || in_data.func == FUNC_ROW_END);
		end
	end

	always_ff @(posedge clk) begin
		mac_s1   <= in_data.func == FUNC_NONZERO;
		close_s1 <= (in_data.func == FUNC_NONZERO && in_data.row_last)
			|| in_data.func == FUNC_ROW_END;
		inr_s1   <= in_range;
		value_s1 <= in_data.value;
	end

	// stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		close_s2 <= close_s1;
		if (mac_s1 && inr_s1) begin
			prod_s2 <= ACC_W'(value_s1) * ACC_W'($signed(rd_data));
		end else begin
			prod_s2 <= '0;
		end
	end

	// accumulate with saturation
	always_comb begin
		sum      = acc_q + prod_s2;
		ovf      = (acc_q[ACC_W-1] == prod_s2[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1]);
		acc_next = sum;
		if (ovf) begin
			acc_next = acc_q[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		sat_next = sat_q || ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			row_q <= '0;
			v_s3  <= 1'b0;
		end else begin
			v_s3 <= v_s2 && close_s2;
			if (v_s2) begin
				if (close_s2) begin
					acc_q <= '0;
					sat_q <= 1'b0;
					row_q <= row_q + 1'b1;
				end else begin
					acc_q <= acc_next;
					sat_q <= sat_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_s3 <= acc_next;
		sat_s3 <= sat_next;
		row_s3 <= row_q;
	end

	// stage 3: scale down and narrow
	always_comb begin
		shifted        = fin_s3 >>> FRAC_BITS;
		fits           = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);
		res.row_number = row_s3;
		res.saturated  = sat_s3 || !fits;
		if (fits) begin
			res.row_sum = shifted[VAL_W-1:0];
		end else begin
			res.row_sum = shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
				: {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// output FIFO
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (v_s3) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (out_fire) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(v_s3) - (FIFO_AW+1)'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wptr_q] <= res;
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_q[rptr_q];

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q + pending) <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("output FIFO overcommitted");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && close_s2) |=> (acc_q == '0 && !sat_q))
		else $error("accumulator not cleared after row close");

	a_row_adv: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (row_q == row_s3 + 1'b1))
		else $error("row counter out of step with result");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (cnt_q < (FIFO_AW+1)'(FIFO_DEPTH) || out_fire))
		else $error("result pushed into full FIFO");

endmodule
